@@ src/csmv_pkg.sv @@
// Shared types, codes and saturation helpers for the scaled CSR matrix-vector core.
// No dependencies; used by csmv_front, csmv_back and csr_sparse_matvec_scaled_core.
package csmv_pkg;

  localparam int unsigned VEC_DEPTH_DEF = 1024;
  localparam int unsigned IDX_W = 10;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned ROW_W = 16;
  localparam int unsigned ACC_W = 48;

  localparam logic [1:0] OP_WRITE   = 2'd0;
  localparam logic [1:0] OP_ENTRY   = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;
  localparam logic [1:0] OP_RESTART = 2'd3;

  localparam logic [1:0] CFG_ALPHA = 2'd0;
  localparam logic [1:0] CFG_BETA  = 2'd1;
  localparam logic [1:0] CFG_TRANS = 2'd2;

  localparam logic signed [31:0] ALPHA_RESET = 32'sd65536;

  typedef enum logic [2:0] {
    K_WR_RAW,
    K_WR_SCALED,
    K_READ,
    K_RESTART,
    K_FWD_ENTRY,
    K_TRN_ENTRY
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [IDX_W-1:0]  vec_index;
    logic [VAL_W-1:0]  vec_value;
    logic [VAL_W-1:0]  matrix_value;
    logic [IDX_W-1:0]  column_index;
    logic              last_in_row;
    logic              entry_present;
    logic [VAL_W-1:0]  row_scalar;
  } cmd_t;

  typedef struct packed {
    logic [VAL_W-1:0] alpha;
    logic [VAL_W-1:0] beta;
    logic             transposed;
  } cfg_t;

  typedef struct packed {
    logic             clip;
    logic [VAL_W-1:0] val;
  } sat_t;

  function automatic sat_t sat32(input logic signed [63:0] v);
    sat_t r;
    if (v > 64'sd2147483647) begin
      r.val  = 32'h7fff_ffff;
      r.clip = 1'b1;
    end else if (v < -64'sd2147483648) begin
      r.val  = 32'h8000_0000;
      r.clip = 1'b1;
    end else begin
      r.val  = v[31:0];
      r.clip = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [ACC_W-1:0] sat48(input logic signed [63:0] v);
    logic [ACC_W-1:0] r;
    if (v > 64'sd140737488355327) begin
      r = {1'b0, {(ACC_W-1){1'b1}}};
    end else if (v < -64'sd140737488355328) begin
      r = {1'b1, {(ACC_W-1){1'b0}}};
    end else begin
      r = v[ACC_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ src/csr_sparse_matvec_scaled_core.sv @@
// Top level of the scaled CSR sparse matrix-vector core: ports, configuration registers.
// Depends on csmv_pkg, csmv_front and csmv_back.
//
// Usage: the slave stream carries commands (tuser holds the opcode and the entry-present
// flag, tlast marks the last entry of a row). Opcode 0 writes the vector store, 1 streams
// one CSR nonzero, 2 reads a store entry back, 3 restarts row numbering. In forward mode
// a row result leaves on the master stream on the row's last (or empty) entry; in
// transposed mode results are only produced by reads. The configuration channel writes
// alpha (index 0), beta (index 1) and the transposed-mode bit (index 2); the user
// writes them only while idle, which the block does not enforce. The sequencer takes
// one command at a time; beta-scaled writes, nonzero entries and forward row closes
// run through the single 33x33 multiplier, used twice per Q16.16 product, and reads
// wait on the registered store read. A two-word queue decouples input acceptance from
// that sequencer.
// Reset clears the queue, row accumulator, row counter and registers (alpha = 1.0);
// the store holds no defined contents until written. When the receiver stalls, the
// result register holds its word, the sequencer waits and the queue fills, then tready
// drops.
module csr_sparse_matvec_scaled_core #(
  parameter int unsigned VEC_DEPTH = csmv_pkg::VEC_DEPTH_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // vec_index[9:0], vec_value[41:10], matrix_value[73:42], column_index[83:74],
  // row_scalar[115:84], zero pad[119:116]
  input  logic [119:0] s_axis_tdata_i,
  // opcode[1:0], entry_present[2]
  input  logic [2:0]   s_axis_tuser_i,
  input  logic         s_axis_tlast_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // out_value[31:0], out_index[47:32], zero pad[63:48]
  output logic [63:0]  m_axis_tdata_o,
  // saturated[0]
  output logic         m_axis_tuser_o,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i
);

  csmv_pkg::cfg_t cfg_q;
  csmv_pkg::cmd_t cmd;
  logic           cmd_valid, cmd_pop;
  logic [31:0]    out_value;
  logic [15:0]    out_index;

  // Registers are always writable; the user must only configure the block while idle.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.alpha      <= csmv_pkg::ALPHA_RESET;
      cfg_q.beta       <= '0;
      cfg_q.transposed <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        csmv_pkg::CFG_ALPHA: cfg_q.alpha      <= cfg_data_i;
        csmv_pkg::CFG_BETA:  cfg_q.beta       <= cfg_data_i;
        csmv_pkg::CFG_TRANS: cfg_q.transposed <= cfg_data_i[0];
        default: ;  // drop writes past the register list
      endcase
    end
  end

  csmv_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (s_axis_tvalid_i),
    .in_ready_o      (s_axis_tready_o),
    .opcode_i        (s_axis_tuser_i[1:0]),
    .vec_index_i     (s_axis_tdata_i[9:0]),
    .vec_value_i     (s_axis_tdata_i[41:10]),
    .matrix_value_i  (s_axis_tdata_i[73:42]),
    .column_index_i  (s_axis_tdata_i[83:74]),
    .last_in_row_i   (s_axis_tlast_i),
    .entry_present_i (s_axis_tuser_i[2]),
    .row_scalar_i    (s_axis_tdata_i[115:84]),
    .transposed_i    (cfg_q.transposed),
    .cmd_o           (cmd),
    .cmd_valid_o     (cmd_valid),
    .cmd_pop_i       (cmd_pop)
  );

  csmv_back #(
    .VEC_DEPTH (VEC_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .cfg_i       (cfg_q),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_value_o (out_value),
    .out_index_o (out_index),
    .out_sat_o   (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {16'd0, out_index, out_value};

endmodule

@@ src/csmv_front.sv @@
// Front end: takes input words, classifies them into commands and queues them.
// Depends on csmv_pkg (cmd_t, kind_e, opcodes).
module csmv_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 opcode_i,
  input  logic [csmv_pkg::IDX_W-1:0] vec_index_i,
  input  logic [csmv_pkg::VAL_W-1:0] vec_value_i,
  input  logic [csmv_pkg::VAL_W-1:0] matrix_value_i,
  input  logic [csmv_pkg::IDX_W-1:0] column_index_i,
  input  logic                       last_in_row_i,
  input  logic                       entry_present_i,
  input  logic [csmv_pkg::VAL_W-1:0] row_scalar_i,
  input  logic                       transposed_i,
  output csmv_pkg::cmd_t             cmd_o,
  output logic                       cmd_valid_o,
  input  logic                       cmd_pop_i
);

  csmv_pkg::cmd_t fifo_q [2];
  csmv_pkg::cmd_t cmd_in;
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     count_q;
  logic           push;

  always_comb begin
    cmd_in.vec_index     = vec_index_i;
    cmd_in.vec_value     = vec_value_i;
    cmd_in.matrix_value  = matrix_value_i;
    cmd_in.column_index  = column_index_i;
    cmd_in.last_in_row   = last_in_row_i;
    cmd_in.entry_present = entry_present_i;
    cmd_in.row_scalar    = row_scalar_i;
    case (opcode_i)
      csmv_pkg::OP_WRITE: cmd_in.kind = transposed_i ? csmv_pkg::K_WR_SCALED
                                                     : csmv_pkg::K_WR_RAW;
      csmv_pkg::OP_ENTRY: cmd_in.kind = transposed_i ? csmv_pkg::K_TRN_ENTRY
                                                     : csmv_pkg::K_FWD_ENTRY;
      csmv_pkg::OP_READ:  cmd_in.kind = csmv_pkg::K_READ;
      default:            cmd_in.kind = csmv_pkg::K_RESTART;
    endcase
  end

  assign in_ready_o  = (count_q != 2'd2);
  assign push        = in_valid_i && in_ready_o;
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_ptr_q] <= cmd_in;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (cmd_pop_i) rd_ptr_q <= ~rd_ptr_q;
      case ({push, cmd_pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

@@ src/csmv_back.sv @@
// Back end: vector store, row accumulator and a shared multiplier sequenced per command.
// Depends on csmv_pkg (cmd_t, cfg_t, sat32, sat48).
module csmv_back #(
  parameter int unsigned VEC_DEPTH = csmv_pkg::VEC_DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  csmv_pkg::cmd_t             cmd_i,
  input  logic                       cmd_valid_i,
  output logic                       cmd_pop_o,
  input  csmv_pkg::cfg_t             cfg_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [csmv_pkg::VAL_W-1:0] out_value_o,
  output logic [csmv_pkg::ROW_W-1:0] out_index_o,
  output logic                       out_sat_o
);

  localparam int unsigned AW = $clog2(VEC_DEPTH);
  localparam int unsigned EW = 17;

  typedef enum logic [2:0] {S_IDLE, S_FETCH, S_RDWAIT, S_MULH, S_MULL, S_MULR} state_e;
  typedef enum logic [2:0] {P_WRS, P_FENT, P_ALPHA, P_BETA, P_SCALE, P_TACC} phase_e;

  logic [32:0] mem [VEC_DEPTH];
  logic [32:0] rdata_q;
  logic        rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [32:0] wr_data;

  state_e state_q;
  phase_e phase_q;
  csmv_pkg::cmd_t cmd_q;
  logic [csmv_pkg::ACC_W-1:0] ma_q, acc_q;
  logic [31:0] mb_q;
  logic signed [79:0] prod_q;
  logic signed [63:0] t_q;
  logic [csmv_pkg::ROW_W-1:0] row_q;
  logic endrow_q;
  logic out_valid_q, out_sat_q;
  logic [31:0] out_value_q;
  logic [csmv_pkg::ROW_W-1:0] out_index_q;

  logic [EW-1:0] vid_ext, col_ext, qvid_ext, qcol_ext;
  logic vid_ok, col_ok, qvid_ok, qcol_ok, out_free, out_load;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic signed [79:0] rsum;
  logic signed [63:0] res, fsum, bsum, tsum;
  csmv_pkg::sat_t sat_w, sat_b, sat_t_acc;

  assign vid_ext  = EW'(cmd_i.vec_index);
  assign col_ext  = EW'(cmd_i.column_index);
  assign qvid_ext = EW'(cmd_q.vec_index);
  assign qcol_ext = EW'(cmd_q.column_index);
  assign vid_ok   = (vid_ext < EW'(VEC_DEPTH));
  assign col_ok   = (col_ext < EW'(VEC_DEPTH));
  assign qvid_ok  = (qvid_ext < EW'(VEC_DEPTH));
  assign qcol_ok  = (qcol_ext < EW'(VEC_DEPTH));
  assign out_free = !out_valid_q || out_ready_i;
  assign out_load = out_free &&
                    (state_q == S_RDWAIT || (state_q == S_MULR && phase_q == P_BETA));

  // Split the wide operand: floor(a / 2^16) times b, then the low 16 bits times b.
  assign mul_a = (state_q == S_MULH) ? 33'($signed(ma_q[47:16])) : $signed({17'd0, ma_q[15:0]});
  assign mul_b = 33'($signed(mb_q));
  assign mul_p = mul_a * mul_b;
  assign rsum  = prod_q + 80'sd32768;
  assign res   = rsum[79:16];
  assign fsum  = 64'($signed(acc_q)) + res;
  assign bsum  = t_q + res;
  assign tsum  = 64'($signed(rdata_q[31:0])) + res;
  assign sat_w     = csmv_pkg::sat32(res);
  assign sat_b     = csmv_pkg::sat32(bsum);
  assign sat_t_acc = csmv_pkg::sat32(tsum);

  assign cmd_pop_o = (state_q == S_IDLE) && cmd_valid_i;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    if (cmd_pop_o) begin
      case (cmd_i.kind)
        csmv_pkg::K_WR_RAW: begin
          wr_en   = vid_ok;
          wr_addr = vid_ext[AW-1:0];
          wr_data = {1'b0, cmd_i.vec_value};
        end
        csmv_pkg::K_READ: begin
          rd_en   = vid_ok;
          rd_addr = vid_ext[AW-1:0];
        end
        csmv_pkg::K_FWD_ENTRY, csmv_pkg::K_TRN_ENTRY: begin
          rd_en   = col_ok && cmd_i.entry_present;
          rd_addr = col_ext[AW-1:0];
        end
        default: ;
      endcase
    end else if (state_q == S_MULR && phase_q == P_WRS) begin
      wr_en   = qvid_ok;
      wr_addr = qvid_ext[AW-1:0];
      wr_data = {sat_w.clip, sat_w.val};
    end else if (state_q == S_MULR && phase_q == P_TACC) begin
      wr_en   = 1'b1;
      wr_addr = qcol_ext[AW-1:0];
      wr_data = {rdata_q[32] | sat_t_acc.clip, sat_t_acc.val};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= P_WRS;
      cmd_q       <= '0;
      ma_q        <= '0;
      mb_q        <= '0;
      prod_q      <= '0;
      t_q         <= '0;
      acc_q       <= '0;
      row_q       <= '0;
      endrow_q    <= 1'b0;
      out_valid_q <= 1'b0;
      out_value_q <= '0;
      out_index_q <= '0;
      out_sat_q   <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            cmd_q    <= cmd_i;
            endrow_q <= !cmd_i.entry_present || cmd_i.last_in_row;
            case (cmd_i.kind)
              csmv_pkg::K_WR_SCALED: begin
                if (vid_ok) begin
                  ma_q    <= 48'($signed(cmd_i.vec_value));
                  mb_q    <= cfg_i.beta;
                  phase_q <= P_WRS;
                  state_q <= S_MULH;
                end
              end
              csmv_pkg::K_READ: state_q <= S_RDWAIT;
              csmv_pkg::K_RESTART: begin
                acc_q <= '0;
                row_q <= '0;
              end
              csmv_pkg::K_FWD_ENTRY: begin
                if (cmd_i.entry_present) begin
                  state_q <= S_FETCH;
                end else begin
                  ma_q    <= acc_q;
                  mb_q    <= cfg_i.alpha;
                  phase_q <= P_ALPHA;
                  state_q <= S_MULH;
                end
              end
              csmv_pkg::K_TRN_ENTRY: begin
                if (cmd_i.entry_present && col_ok) begin
                  ma_q    <= 48'($signed(cfg_i.alpha));
                  mb_q    <= cmd_i.row_scalar;
                  phase_q <= P_SCALE;
                  state_q <= S_MULH;
                end else if (!cmd_i.entry_present || cmd_i.last_in_row) begin
                  acc_q <= '0;
                  row_q <= row_q + csmv_pkg::ROW_W'(1);
                end
              end
              default: ;
            endcase
          end
        end
        S_FETCH: begin
          ma_q    <= 48'($signed(cmd_q.matrix_value));
          mb_q    <= qcol_ok ? rdata_q[31:0] : '0;
          phase_q <= P_FENT;
          state_q <= S_MULH;
        end
        S_RDWAIT: begin
          if (out_free) begin
            out_value_q <= qvid_ok ? rdata_q[31:0] : '0;
            out_sat_q   <= qvid_ok && rdata_q[32];
            out_index_q <= csmv_pkg::ROW_W'(cmd_q.vec_index);
            state_q     <= S_IDLE;
          end
        end
        S_MULH: begin
          prod_q  <= 80'(mul_p);
          state_q <= S_MULL;
        end
        S_MULL: begin
          prod_q  <= (prod_q <<< 16) + 80'(mul_p);
          state_q <= S_MULR;
        end
        S_MULR: begin
          case (phase_q)
            P_WRS: state_q <= S_IDLE;
            P_FENT: begin
              acc_q <= csmv_pkg::sat48(fsum);
              if (endrow_q) begin
                ma_q    <= csmv_pkg::sat48(fsum);
                mb_q    <= cfg_i.alpha;
                phase_q <= P_ALPHA;
                state_q <= S_MULH;
              end else begin
                state_q <= S_IDLE;
              end
            end
            P_ALPHA: begin
              t_q     <= res;
              ma_q    <= 48'($signed(cmd_q.row_scalar));
              mb_q    <= cfg_i.beta;
              phase_q <= P_BETA;
              state_q <= S_MULH;
            end
            P_BETA: begin
              if (out_free) begin
                out_value_q <= sat_b.val;
                out_sat_q   <= sat_b.clip;
                out_index_q <= row_q;
                acc_q       <= '0;
                row_q       <= row_q + csmv_pkg::ROW_W'(1);
                state_q     <= S_IDLE;
              end
            end
            P_SCALE: begin
              ma_q    <= res[47:0];
              mb_q    <= cmd_q.matrix_value;
              phase_q <= P_TACC;
              state_q <= S_MULH;
            end
            P_TACC: begin
              if (endrow_q) begin
                acc_q <= '0;
                row_q <= row_q + csmv_pkg::ROW_W'(1);
              end
              state_q <= S_IDLE;
            end
            default: state_q <= S_IDLE;
          endcase
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign out_index_o = out_index_q;
  assign out_sat_o   = out_sat_q;

`ifndef NO_ASSERTIONS
  a_mulh_then_mull: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MULH |=> state_q == S_MULL)
    else $error("high partial product not followed by low partial product");

  a_pop_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> state_q == S_IDLE && cmd_valid_i)
    else $error("command popped outside idle");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_MULR || state_q == S_RDWAIT))
    else $error("result raised from an unexpected state");
`endif

endmodule

@@ tb/tb_top.sv @@
// Self-checking bench for csr_sparse_matvec_scaled_core: stream driver, result monitor
// and a Q16.16 predictor of rows, store writes and read-backs. Depends on csmv_pkg.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 500000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [1:0]  op;
    logic [9:0]  vidx;
    logic [31:0] vval;
    logic [31:0] mval;
    logic [9:0]  col;
    logic        last;
    logic        pres;
    logic [31:0] rs;
  } cmd_word_t;

  typedef struct packed {
    logic [31:0] val;
    logic [15:0] idx;
    logic        sat;
  } result_word_t;

  logic clk, rst_n;
  logic s_valid, s_tready;
  logic m_valid, m_ready, m_tuser;
  logic [63:0] m_tdata;
  logic cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  logic [31:0] cfg_data;
  cmd_word_t cur;

  cmd_word_t    pend_q[$];
  result_word_t row_results_q[$];

  // predictor state
  logic signed [31:0] vec_mem [1024];
  bit                 vec_clip [1024];
  longint             row_acc;
  logic [15:0]        row_num;
  longint             alpha_r, beta_r;
  bit                 trans_r;

  // stimulus bookkeeping
  int written_q[$];
  bit gen_trans;
  int idle_mode;   // 0 none, 1 sender, 2 receiver, 3 both
  int errors;
  int cycles;
  bit s_acc;
  bit hold_go;
  int hold_left;

  csr_sparse_matvec_scaled_core uut (
    .clk_i(clk), .rst_ni(rst_n),
    .s_axis_tvalid_i(s_valid), .s_axis_tready_o(s_tready),
    .s_axis_tdata_i({4'b0, cur.rs, cur.col, cur.mval, cur.vval, cur.vidx}),
    .s_axis_tuser_i({cur.pres, cur.op}),
    .s_axis_tlast_i(cur.last),
    .m_axis_tvalid_o(m_valid), .m_axis_tready_i(m_ready),
    .m_axis_tdata_o(m_tdata), .m_axis_tuser_o(m_tuser),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Round-half-up Q16.16 product: floor((a*b + 2^15) / 2^16).
  function automatic longint qmul(longint a, longint b);
    logic signed [127:0] p;
    p = a;
    p = p * b + 32768;
    return longint'(p >>> 16);
  endfunction

  function automatic longint clip32(longint v, ref bit c);
    if (v > 64'sd2147483647) begin
      c = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      c = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // Advance the predictor by one accepted word; queue the result it causes.
  task automatic predict_word(input cmd_word_t w);
    bit c;
    longint s, t;
    result_word_t r;
    c = 1'b0;
    case (w.op)
      csmv_pkg::OP_WRITE: begin
        if (trans_r) vec_mem[w.vidx] = 32'(clip32(qmul(longint'($signed(w.vval)), beta_r), c));
        else vec_mem[w.vidx] = w.vval;
        vec_clip[w.vidx] = c;
      end
      csmv_pkg::OP_READ: begin
        r.val = vec_mem[w.vidx];
        r.idx = 16'(w.vidx);
        r.sat = vec_clip[w.vidx];
        row_results_q.push_back(r);
      end
      csmv_pkg::OP_RESTART: begin
        row_acc = 0;
        row_num = '0;
      end
      default: begin
        if (!trans_r) begin
          if (w.pres) begin
            s = row_acc + qmul(longint'($signed(w.mval)), longint'(vec_mem[w.col]));
            if (s > 64'sd140737488355327) s = 64'sd140737488355327;
            if (s < -64'sd140737488355328) s = -64'sd140737488355328;
            row_acc = s;
          end
          if (!w.pres || w.last) begin
            t = qmul(row_acc, alpha_r) + qmul(longint'($signed(w.rs)), beta_r);
            r.val = 32'(clip32(t, c));
            r.idx = row_num;
            r.sat = c;
            row_results_q.push_back(r);
          end
        end else if (w.pres) begin
          t = longint'(vec_mem[w.col])
              + qmul(qmul(alpha_r, longint'($signed(w.rs))), longint'($signed(w.mval)));
          vec_mem[w.col] = 32'(clip32(t, c));
          if (c) vec_clip[w.col] = 1'b1;
        end
        if (!w.pres || w.last) begin
          row_acc = 0;
          row_num = row_num + 16'd1;
        end
      end
    endcase
  endtask

  // Hold the word until accepted, then advance to the next pending one.
  always @(negedge clk) begin
    if (rst_n && (!s_valid || s_acc)) begin
      if (pend_q.size() > 0 &&
          !((idle_mode == 1 || idle_mode == 3) &&
            $urandom_range(0, 99) < (idle_mode == 3 ? 29 : 85))) begin
        cur = pend_q.pop_front();
        s_valid <= 1'b1;
      end else begin
        s_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  always @(negedge clk) begin
    if (hold_go) begin
      hold_go = 1'b0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_ready <= 1'b0;
    end else begin
      m_ready <= !((idle_mode == 2 || idle_mode == 3) &&
                   $urandom_range(0, 99) < (idle_mode == 3 ? 29 : 85));
    end
  end

  // Monitor: predict on input acceptance, compare on output acceptance.
  always @(posedge clk) begin
    result_word_t e;
    s_acc = rst_n && s_valid && s_tready;
    if (rst_n && m_valid && m_ready) begin
      if (row_results_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word %h/%b", m_tdata, m_tuser);
      end else begin
        e = row_results_q.pop_front();
        if (m_tdata[31:0] !== e.val || m_tdata[47:32] !== e.idx || m_tuser !== e.sat) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected val %h idx %0d sat %b, got val %h idx %0d sat %b",
                     e.val, e.idx, e.sat, m_tdata[31:0], m_tdata[47:32], m_tuser);
        end
      end
    end
    if (s_acc) predict_word(cur);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [31:0] rand_val();
    if ($urandom_range(0, 1)) return $urandom;
    return 32'($urandom_range(0, 32'h7ffff)) - 32'h40000;
  endfunction

  function automatic logic [9:0] pick_written();
    return 10'(written_q[$urandom_range(0, written_q.size() - 1)]);
  endfunction

  // Fill every field at random, then set the ones the opcode uses.
  function automatic cmd_word_t noise_word(logic [1:0] op);
    cmd_word_t w;
    w = 120'({$urandom, $urandom, $urandom, $urandom});
    w.op = op;
    return w;
  endfunction

  task automatic add_write(logic [9:0] idx, logic [31:0] v);
    cmd_word_t w;
    w = noise_word(csmv_pkg::OP_WRITE);
    w.vidx = idx;
    w.vval = v;
    pend_q.push_back(w);
    written_q.push_back(idx);
  endtask

  task automatic add_read(logic [9:0] idx);
    cmd_word_t w;
    w = noise_word(csmv_pkg::OP_READ);
    w.vidx = idx;
    pend_q.push_back(w);
  endtask

  task automatic add_entry(logic [9:0] col, logic [31:0] mv, logic [31:0] rs, bit last,
                           bit pres);
    cmd_word_t w;
    w = noise_word(csmv_pkg::OP_ENTRY);
    w.col = col;
    w.mval = mv;
    w.rs = rs;
    w.last = last;
    w.pres = pres;
    pend_q.push_back(w);
  endtask

  // Mostly well-formed rows with random content; some noise.
  task automatic gen_random(int count);
    int n, r, len;
    n = 0;
    while (n < count) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        add_write(10'($urandom), rand_val());
        n++;
      end else if (r < 27) begin
        add_read(pick_written());
        n++;
      end else if (r < 31) begin
        pend_q.push_back(noise_word(csmv_pkg::OP_RESTART));
        n++;
      end else if (r < 37) begin
        add_entry(10'($urandom), $urandom, rand_val(), 1'($urandom_range(0, 1)), 1'b0);
        n++;
      end else if (r < 42) begin
        add_entry(pick_written(), rand_val(), rand_val(), 1'($urandom_range(0, 1)), 1'b1);
        n++;
      end else begin
        len = $urandom_range(1, 4);
        for (int i = 0; i < len; i++)
          add_entry(pick_written(), rand_val(), rand_val(), i == len - 1, 1'b1);
        n += len;
      end
    end
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      csmv_pkg::CFG_ALPHA: alpha_r = longint'($signed(data));
      csmv_pkg::CFG_BETA:  beta_r = longint'($signed(data));
      default:             trans_r = data[0];
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Wait out every queued word and result, then let in-flight writes settle.
  task automatic wait_quiet();
    wait (pend_q.size() == 0 && !s_valid && row_results_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_regs(logic [31:0] a, logic [31:0] b, bit tr);
    cfg_write(csmv_pkg::CFG_ALPHA, a);
    cfg_write(csmv_pkg::CFG_BETA, b);
    cfg_write(csmv_pkg::CFG_TRANS, {31'b0, tr});
  endtask

  logic [31:0] alpha_set [8] = '{32'h0001_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000,
                                 32'h0000_8000, 32'hffff_0000, 32'h0002_0000, 32'h0001_0000};
  logic [31:0] beta_set  [8] = '{32'h0000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h0001_0000,
                                 32'hffff_8000, 32'h0000_4000, 32'h0000_0000, 32'h0001_8000};

  initial begin
    rst_n = 1'b0;
    s_valid = 1'b0;
    m_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cur = '0;
    errors = 0;
    cycles = 0;
    idle_mode = 0;
    hold_go = 1'b0;
    hold_left = 0;
    row_acc = 0;
    row_num = '0;
    alpha_r = 65536;
    beta_r = 0;
    trans_r = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed, forward mode with reset registers: extreme store values and products.
    add_write(10'd0, 32'h7fff_ffff);
    add_write(10'd1023, 32'h8000_0000);
    add_write(10'd5, 32'h0001_0000);
    add_entry(10'd0, 32'h7fff_ffff, 32'h0, 1'b1, 1'b1);
    add_entry(10'd1023, 32'h8000_0000, 32'h0, 1'b1, 1'b1);
    add_entry(10'd5, 32'h0002_0000, 32'h0, 1'b0, 1'b1);
    add_entry(10'd5, 32'hffff_8000, 32'h0, 1'b1, 1'b1);
    add_entry(10'd0, 32'h0, 32'h7fff_ffff, 1'b0, 1'b0);
    for (int i = 0; i < 6; i++) add_entry(10'd0, 32'h7fff_ffff, 32'h0, i == 5, 1'b1);
    pend_q.push_back(noise_word(csmv_pkg::OP_RESTART));
    add_entry(10'd5, 32'h0000_8000, 32'h0, 1'b1, 1'b1);
    add_read(10'd1023);
    add_read(10'd0);
    wait_quiet();

    // Directed, transposed mode: beta-scaled writes, clipped accumulation, read-back.
    set_regs(32'h7fff_ffff, 32'h7fff_ffff, 1'b1);
    add_write(10'd7, 32'h7fff_ffff);
    add_write(10'd8, 32'h0000_0001);
    add_entry(10'd8, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1, 1'b1);
    add_entry(10'd8, 32'h0, 32'h0, 1'b1, 1'b0);
    add_read(10'd7);
    add_read(10'd8);
    wait_quiet();

    for (int ph = 0; ph < 8; ph++) begin
      gen_trans = ph[0];
      set_regs(alpha_set[ph], beta_set[ph], gen_trans);
      idle_mode = ph % 4;
      gen_random(65);
      // Hold the receiver off while the sender keeps offering words.
      if (ph == 0) hold_go = 1'b1;
      wait_quiet();
    end

    idle_mode = 0;
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/csmv_pkg.sv
src/csmv_front.sv
src/csmv_back.sv
src/csr_sparse_matvec_scaled_core.sv
tb/tb_top.sv
